### hdl/gn3_pkg.sv
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared constants, the permutation ROM and the edge gradient table for the
// 3D gradient noise core.
// ----------------------------------------------------------------------------
`default_nettype none

package gn3_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int POS_W         = 32;
  localparam int VALUE_W       = 19;
  localparam int GRAD_W        = 22;
  localparam int SEL_W         = 4;
  localparam int GK_W          = 5;

  // One edge gradient, each component in {-1, 0, +1}.
  typedef struct packed {
    logic signed [1:0] gx;
    logic signed [1:0] gy;
    logic signed [1:0] gz;
  } grad_t;

  localparam grad_t GRAD_TAB [12] = '{
    '{ 2'sd1,  2'sd1,  2'sd0}, '{-2'sd1,  2'sd1,  2'sd0},
    '{ 2'sd1, -2'sd1,  2'sd0}, '{-2'sd1, -2'sd1,  2'sd0},
    '{ 2'sd1,  2'sd0,  2'sd1}, '{-2'sd1,  2'sd0,  2'sd1},
    '{ 2'sd1,  2'sd0, -2'sd1}, '{-2'sd1,  2'sd0, -2'sd1},
    '{ 2'sd0,  2'sd1,  2'sd1}, '{ 2'sd0, -2'sd1,  2'sd1},
    '{ 2'sd0,  2'sd1, -2'sd1}, '{ 2'sd0, -2'sd1, -2'sd1}
  };

  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13,
    8'd201, 8'd95, 8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225,
    8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
    8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148,
    8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
    8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
    8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87,
    8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175,
    8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
    8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
    8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
    8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
    8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73,
    8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64,
    8'd52, 8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202,
    8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
    8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17,
    8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
    8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110,
    8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241,
    8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
    8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45,
    8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141,
    8'd128, 8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
  };

  // Byte modulo 12 by a short chain of compare and subtract steps.
  function automatic logic [SEL_W-1:0] mod12(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd192) r = r - 8'd192;
    if (r >= 8'd96)  r = r - 8'd96;
    if (r >= 8'd48)  r = r - 8'd48;
    if (r >= 8'd24)  r = r - 8'd24;
    if (r >= 8'd12)  r = r - 8'd12;
    return r[SEL_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/gn3_if.sv
// ----------------------------------------------------------------------------
// gn3 channel interfaces
// Valid/ready channels for the point items going in and the result items
// coming out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gn3_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [gn3_pkg::POS_W-1:0]    pos_x;
  logic signed [gn3_pkg::POS_W-1:0]    pos_y;
  logic signed [gn3_pkg::POS_W-1:0]    pos_z;
  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface gn3_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [gn3_pkg::VALUE_W-1:0]  noise_value;
  logic signed [gn3_pkg::GRAD_W-1:0]   grad_x;
  logic signed [gn3_pkg::GRAD_W-1:0]   grad_y;
  logic signed [gn3_pkg::GRAD_W-1:0]   grad_z;
  modport source (output valid, output noise_value, output grad_x, output grad_y,
                  output grad_z, input ready);
  modport sink   (input valid, input noise_value, input grad_x, input grad_y,
                  input grad_z, output ready);
endinterface

`default_nettype wire

### hdl/gn3_fade.sv
// ----------------------------------------------------------------------------
// gn3_fade
// Three-stage quintic fade weight and its slope for one axis.
// ----------------------------------------------------------------------------
`default_nettype none

module gn3_fade #(
  parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [FRAC_BITS-1:0]        frac,
  output logic signed [FRAC_BITS+2:0] fade,
  output logic signed [FRAC_BITS+2:0] slope
);

  localparam int FW = FRAC_BITS + 6;
  localparam int PW = 2 * FW;
  localparam logic signed [PW-1:0] HALF  = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [FW-1:0] ONE   = FW'(1) <<< FRAC_BITS;
  localparam logic signed [FW-1:0] ONE10 = FW'(10) <<< FRAC_BITS;
  localparam logic signed [FW-1:0] ONE15 = FW'(15) <<< FRAC_BITS;

  function automatic logic signed [FW-1:0] qmul(input logic signed [FW-1:0] a,
                                                input logic signed [FW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + HALF;
    return FW'(p >>> FRAC_BITS);
  endfunction

  logic signed [FW-1:0] fe;
  logic signed [FW-1:0] f1_r, ff_r, q_r, t_r;
  logic signed [FW-1:0] fff_r, qq_r, t2_r;
  logic signed [FW-1:0] u_r, du_r;

  assign fe = FW'($signed({1'b0, frac}));

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r  <= fe;
      ff_r  <= qmul(fe, fe);
      q_r   <= qmul(fe, fe - ONE);
      t_r   <= qmul(fe, (fe <<< 2) + (fe <<< 1) - ONE15) + ONE10;
      fff_r <= qmul(ff_r, f1_r);
      qq_r  <= qmul(q_r, q_r);
      t2_r  <= t_r;
      u_r   <= qmul(fff_r, t2_r);
      du_r  <= (qq_r <<< 5) - (qq_r <<< 1);
    end
  end

  assign fade  = u_r[FRAC_BITS+2:0];
  assign slope = du_r[FRAC_BITS+2:0];

endmodule

`default_nettype wire

### hdl/gn3_hash.sv
// ----------------------------------------------------------------------------
// gn3_hash
// Three-stage corner hash: one permutation ROM level per stage, giving the
// gradient select for all eight cell corners.
// ----------------------------------------------------------------------------
`default_nettype none

module gn3_hash #(
  parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [7:0]                   cell_x,
  input  logic [7:0]                   cell_y,
  input  logic [7:0]                   cell_z,
  input  logic [FRAC_BITS-1:0]         frac_x,
  input  logic [FRAC_BITS-1:0]         frac_y,
  input  logic [FRAC_BITS-1:0]         frac_z,
  output logic [gn3_pkg::SEL_W-1:0]    sel [8],
  output logic [FRAC_BITS-1:0]         frac_x_o,
  output logic [FRAC_BITS-1:0]         frac_y_o,
  output logic [FRAC_BITS-1:0]         frac_z_o
);

  logic [7:0] a_r [2];
  logic [7:0] b_r [4];
  logic [gn3_pkg::SEL_W-1:0] s_r [8];
  logic [7:0] cy1_r, cz1_r, cz2_r;
  logic [FRAC_BITS-1:0] fx_r [3];
  logic [FRAC_BITS-1:0] fy_r [3];
  logic [FRAC_BITS-1:0] fz_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= gn3_pkg::PERM[cell_x];
      a_r[1] <= gn3_pkg::PERM[8'(cell_x + 8'd1)];
      cy1_r  <= cell_y;
      cz1_r  <= cell_z;
      for (int c = 0; c < 4; c++) begin
        b_r[c] <= gn3_pkg::PERM[8'(a_r[c % 2] + cy1_r + 8'(c / 2))];
      end
      cz2_r <= cz1_r;
      for (int c = 0; c < 8; c++) begin
        s_r[c] <= gn3_pkg::mod12(gn3_pkg::PERM[8'(b_r[c % 4] + cz2_r + 8'(c / 4))]);
      end
      fx_r[0] <= frac_x;
      fy_r[0] <= frac_y;
      fz_r[0] <= frac_z;
      for (int s = 1; s < 3; s++) begin
        fx_r[s] <= fx_r[s-1];
        fy_r[s] <= fy_r[s-1];
        fz_r[s] <= fz_r[s-1];
      end
    end
  end

  assign sel      = s_r;
  assign frac_x_o = fx_r[2];
  assign frac_y_o = fy_r[2];
  assign frac_z_o = fz_r[2];

endmodule

`default_nettype wire

### hdl/gn3_blend.sv
// ----------------------------------------------------------------------------
// gn3_blend
// Four-stage corner dot products, trilinear blend with fade weights, chain
// rule for the partials and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module gn3_blend #(
  parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [gn3_pkg::SEL_W-1:0]          sel [8],
  input  logic [FRAC_BITS-1:0]               frac_x,
  input  logic [FRAC_BITS-1:0]               frac_y,
  input  logic [FRAC_BITS-1:0]               frac_z,
  input  logic signed [FRAC_BITS+2:0]        fade [3],
  input  logic signed [FRAC_BITS+2:0]        slope [3],
  output logic signed [gn3_pkg::VALUE_W-1:0] noise_value,
  output logic signed [gn3_pkg::GRAD_W-1:0]  grad_x,
  output logic signed [gn3_pkg::GRAD_W-1:0]  grad_y,
  output logic signed [gn3_pkg::GRAD_W-1:0]  grad_z
);

  localparam int W  = FRAC_BITS + 8;
  localparam int PW = 2 * W;
  localparam int GK = gn3_pkg::GK_W;
  localparam int SW = (W > gn3_pkg::GRAD_W) ? W : gn3_pkg::GRAD_W;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [W-1:0]  ONE  = W'(1) <<< FRAC_BITS;
  localparam logic signed [SW-1:0] VHI  = (SW'(1) <<< (gn3_pkg::VALUE_W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] VLO  = -VHI - SW'(1);
  localparam logic signed [SW-1:0] GHI  = (SW'(1) <<< (gn3_pkg::GRAD_W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] GLO  = -GHI - SW'(1);

  typedef struct packed {
    logic signed [W-1:0] p0, kx, ky, kz, kxy, kyz, kzx, kall;
  } kset_t;

  typedef struct packed {
    logic signed [GK-1:0] p0, kx, ky, kz, kxy, kyz, kzx, kall;
  } gset_t;

  function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + HALF;
    return W'(p >>> FRAC_BITS);
  endfunction

  // Fade weight times a small integer: exact, as the gradient terms are whole.
  function automatic logic signed [W-1:0] smul(input logic signed [W-1:0] a,
                                               input logic signed [GK-1:0] k);
    logic signed [W+GK-1:0] p;
    p = (W+GK)'(a) * (W+GK)'(k);
    return W'(p);
  endfunction

  function automatic logic signed [W-1:0] gterm(input logic signed [1:0] g,
                                                input logic signed [W-1:0] o);
    logic signed [W-1:0] r;
    case (g)
      2'sb01:  r = o;
      2'sb11:  r = -o;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic kset_t mkset(input logic signed [W-1:0] p [8]);
    kset_t k;
    k.p0   = p[0];
    k.kx   = p[1] - p[0];
    k.ky   = p[2] - p[0];
    k.kz   = p[4] - p[0];
    k.kxy  = p[0] - p[1] - p[2] + p[3];
    k.kyz  = p[0] - p[2] - p[4] + p[6];
    k.kzx  = p[0] - p[1] - p[4] + p[5];
    k.kall = -p[0] + p[1] + p[2] - p[3] + p[4] - p[5] - p[6] + p[7];
    return k;
  endfunction

  function automatic gset_t mkgset(input logic signed [GK-1:0] p [8]);
    gset_t k;
    k.p0   = p[0];
    k.kx   = p[1] - p[0];
    k.ky   = p[2] - p[0];
    k.kz   = p[4] - p[0];
    k.kxy  = p[0] - p[1] - p[2] + p[3];
    k.kyz  = p[0] - p[2] - p[4] + p[6];
    k.kzx  = p[0] - p[1] - p[4] + p[5];
    k.kall = -p[0] + p[1] + p[2] - p[3] + p[4] - p[5] - p[6] + p[7];
    return k;
  endfunction

  function automatic logic signed [gn3_pkg::VALUE_W-1:0] sat_value(
      input logic signed [W-1:0] v);
    logic signed [SW-1:0] e;
    e = SW'(v);
    if (e > VHI) e = VHI;
    if (e < VLO) e = VLO;
    return e[gn3_pkg::VALUE_W-1:0];
  endfunction

  function automatic logic signed [gn3_pkg::GRAD_W-1:0] sat_grad(
      input logic signed [W-1:0] v);
    logic signed [SW-1:0] e;
    e = SW'(v);
    if (e > GHI) e = GHI;
    if (e < GLO) e = GLO;
    return e[gn3_pkg::GRAD_W-1:0];
  endfunction

  // Stage 4 logic: corner dot products and blend coefficients.
  logic signed [W-1:0]  dotv [8];
  logic signed [GK-1:0] gcx [8];
  logic signed [GK-1:0] gcy [8];
  logic signed [GK-1:0] gcz [8];
  logic signed [W-1:0]  fxw, fyw, fzw;

  assign fxw = W'($signed({1'b0, frac_x}));
  assign fyw = W'($signed({1'b0, frac_y}));
  assign fzw = W'($signed({1'b0, frac_z}));

  always_comb begin
    gn3_pkg::grad_t g;
    logic signed [W-1:0] ox, oy, oz;
    for (int c = 0; c < 8; c++) begin
      g       = gn3_pkg::GRAD_TAB[sel[c]];
      ox      = ((c % 2) != 0)       ? fxw - ONE : fxw;
      oy      = (((c / 2) % 2) != 0) ? fyw - ONE : fyw;
      oz      = ((c / 4) != 0)       ? fzw - ONE : fzw;
      dotv[c] = gterm(g.gx, ox) + gterm(g.gy, oy) + gterm(g.gz, oz);
      gcx[c]  = GK'(g.gx);
      gcy[c]  = GK'(g.gy);
      gcz[c]  = GK'(g.gz);
    end
  end

  // Stage 4 registers.
  kset_t               k4_r;
  gset_t               g4_r [3];
  logic signed [W-1:0] u4_r [3];
  logic signed [W-1:0] du4_r [3];
  logic signed [W-1:0] uxy4_r, uyz4_r, uzx4_r;

  // Stage 5 registers.
  logic signed [W-1:0] uxyz5_r, val5_r, kall5_r;
  logic signed [W-1:0] s5_r [3];
  logic signed [W-1:0] gp5_r [3];
  logic signed [GK-1:0] gkall5_r [3];
  logic signed [W-1:0] du5_r [3];

  // Stage 6 and output registers.
  logic signed [W-1:0] val6_r;
  logic signed [W-1:0] d6_r [3];
  logic signed [gn3_pkg::VALUE_W-1:0] val7_r;
  logic signed [gn3_pkg::GRAD_W-1:0]  d7_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      k4_r    <= mkset(dotv);
      g4_r[0] <= mkgset(gcx);
      g4_r[1] <= mkgset(gcy);
      g4_r[2] <= mkgset(gcz);
      for (int a = 0; a < 3; a++) begin
        u4_r[a]  <= W'(fade[a]);
        du4_r[a] <= W'(slope[a]);
      end
      uxy4_r <= qmul(W'(fade[0]), W'(fade[1]));
      uyz4_r <= qmul(W'(fade[1]), W'(fade[2]));
      uzx4_r <= qmul(W'(fade[2]), W'(fade[0]));

      uxyz5_r <= qmul(uxy4_r, u4_r[2]);
      val5_r  <= k4_r.p0 + qmul(u4_r[0], k4_r.kx) + qmul(u4_r[1], k4_r.ky)
               + qmul(u4_r[2], k4_r.kz) + qmul(uxy4_r, k4_r.kxy)
               + qmul(uyz4_r, k4_r.kyz) + qmul(uzx4_r, k4_r.kzx);
      kall5_r <= k4_r.kall;
      s5_r[0] <= k4_r.kx + qmul(u4_r[1], k4_r.kxy) + qmul(u4_r[2], k4_r.kzx)
               + qmul(uyz4_r, k4_r.kall);
      s5_r[1] <= k4_r.ky + qmul(u4_r[2], k4_r.kyz) + qmul(u4_r[0], k4_r.kxy)
               + qmul(uzx4_r, k4_r.kall);
      s5_r[2] <= k4_r.kz + qmul(u4_r[0], k4_r.kzx) + qmul(u4_r[1], k4_r.kyz)
               + qmul(uxy4_r, k4_r.kall);
      for (int a = 0; a < 3; a++) begin
        gp5_r[a] <= (W'(g4_r[a].p0) <<< FRAC_BITS)
                  + smul(u4_r[0], g4_r[a].kx) + smul(u4_r[1], g4_r[a].ky)
                  + smul(u4_r[2], g4_r[a].kz) + smul(uxy4_r, g4_r[a].kxy)
                  + smul(uyz4_r, g4_r[a].kyz) + smul(uzx4_r, g4_r[a].kzx);
        gkall5_r[a] <= g4_r[a].kall;
        du5_r[a]    <= du4_r[a];
      end

      val6_r <= val5_r + qmul(uxyz5_r, kall5_r);
      for (int a = 0; a < 3; a++) begin
        d6_r[a] <= gp5_r[a] + smul(uxyz5_r, gkall5_r[a]) + qmul(du5_r[a], s5_r[a]);
      end

      val7_r <= sat_value(val6_r);
      for (int a = 0; a < 3; a++) begin
        d7_r[a] <= sat_grad(d6_r[a]);
      end
    end
  end

  assign noise_value = val7_r;
  assign grad_x      = d7_r[0];
  assign grad_y      = d7_r[1];
  assign grad_z      = d7_r[2];

endmodule

`default_nettype wire

### hdl/gradient_noise_3d_with_derivative_core.sv
// ----------------------------------------------------------------------------
// gradient_noise_3d_with_derivative_core
// 3D gradient noise with analytic partial derivatives, one point per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage: an item on in_chan carries a point (pos_x, pos_y, pos_z) in signed
// fixed point with FRAC_BITS fraction bits. An item on out_chan carries the
// noise value and its three partial derivatives, saturated to their fields.
// Both channels use a valid/ready handshake; an item moves on a clock edge
// at which valid and ready are both high.
// From acceptance to out_chan.valid an item passes through three stages
// of fade polynomial and corner hashing (one permutation ROM level per
// stage), then dot products, first blend products, final blend and chain
// rule products, and the saturating output register.
// Throughput is one item per cycle while the output is not stalled; a new
// item is taken while earlier ones are still in flight.
// When the receiver holds out_chan.ready low while a result waits, the whole
// pipeline freezes and in_chan.ready drops; nothing is lost or repeated.
// Bubbles further up are held during such a stall as well, but ready stays
// high whenever the output register is empty.
// Reset clears the stage valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_noise_3d_with_derivative_core #(
  parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  gn3_in_if.sink           in_chan,
  gn3_out_if.source        out_chan
);

  localparam int DEPTH = 7;

  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic             en;

  // The pipeline moves as one; it only holds when a finished result is
  // waiting in the output register and the receiver is not taking it.
  assign en            = !vld_r[DEPTH-1] || out_chan.ready;
  assign in_chan.ready = en;
  assign vld_nxt       = {vld_r[DEPTH-2:0], in_chan.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Split each coordinate into its wrapped lattice cell and its fraction.
  logic [7:0]           cell_x, cell_y, cell_z;
  logic [FRAC_BITS-1:0] frac [3];

  assign cell_x  = in_chan.pos_x[FRAC_BITS+7:FRAC_BITS];
  assign cell_y  = in_chan.pos_y[FRAC_BITS+7:FRAC_BITS];
  assign cell_z  = in_chan.pos_z[FRAC_BITS+7:FRAC_BITS];
  assign frac[0] = in_chan.pos_x[FRAC_BITS-1:0];
  assign frac[1] = in_chan.pos_y[FRAC_BITS-1:0];
  assign frac[2] = in_chan.pos_z[FRAC_BITS-1:0];

  logic signed [FRAC_BITS+2:0] fade [3];
  logic signed [FRAC_BITS+2:0] slope [3];

  for (genvar a = 0; a < 3; a++) begin : g_fade
    gn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade (
      .clk   (clk),
      .en    (en),
      .frac  (frac[a]),
      .fade  (fade[a]),
      .slope (slope[a])
    );
  end

  logic [gn3_pkg::SEL_W-1:0] sel [8];
  logic [FRAC_BITS-1:0]      fx3, fy3, fz3;

  gn3_hash #(.FRAC_BITS(FRAC_BITS)) u_hash (
    .clk      (clk),
    .en       (en),
    .cell_x   (cell_x),
    .cell_y   (cell_y),
    .cell_z   (cell_z),
    .frac_x   (frac[0]),
    .frac_y   (frac[1]),
    .frac_z   (frac[2]),
    .sel      (sel),
    .frac_x_o (fx3),
    .frac_y_o (fy3),
    .frac_z_o (fz3)
  );

  gn3_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk         (clk),
    .en          (en),
    .sel         (sel),
    .frac_x      (fx3),
    .frac_y      (fy3),
    .frac_z      (fz3),
    .fade        (fade),
    .slope       (slope),
    .noise_value (out_chan.noise_value),
    .grad_x      (out_chan.grad_x),
    .grad_y      (out_chan.grad_y),
    .grad_z      (out_chan.grad_z)
  );

  assign out_chan.valid = vld_r[DEPTH-1];

`ifndef SYNTHESIS
  // An empty output register must never block the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[DEPTH-1] |-> in_chan.ready)
    else $error("input stalled with an empty output register");

  // An accepted item must occupy the first stage on the next cycle.
  a_enter_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> vld_r[0])
    else $error("accepted item missing from the first stage");

  // A stalled result freezes every stage valid bit.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=> $stable(vld_r))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule

`default_nettype wire

### tb/sv/gradient_noise_3d_with_derivative_checker.sv
// ----------------------------------------------------------------------------
// gradient_noise_3d_with_derivative_checker
// Watches both channels of the noise core, computes the expected noise value
// and gradient for every accepted point and compares each result item.
// ----------------------------------------------------------------------------
module gradient_noise_3d_with_derivative_checker (
  input  logic  clk,
  input  logic  rst_n,
  gn3_in_if     in_mon,
  gn3_out_if    out_mon,
  output int    fail_count,
  output int    pending_count,
  output int    result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = gn3_pkg::FRAC_BITS_DEF;
  localparam int VW = gn3_pkg::VALUE_W;
  localparam int GW = gn3_pkg::GRAD_W;
  localparam longint ONE = 64'sd1 <<< FB;

  typedef struct {
    logic signed [VW-1:0] noise_value;
    logic signed [GW-1:0] grad_x;
    logic signed [GW-1:0] grad_y;
    logic signed [GW-1:0] grad_z;
  } noise_res_t;

  noise_res_t expected_q[$];

  // Round to nearest, ties upward; >>> on a longint is a floor shift.
  function automatic longint rmul(longint a, longint b);
    return (a * b + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint mix8(longint p[8], longint ux, longint uy, longint uz,
                                  longint uxy, longint uyz, longint uzx, longint uxyz);
    return p[0] + rmul(ux, p[1] - p[0]) + rmul(uy, p[2] - p[0]) + rmul(uz, p[4] - p[0])
         + rmul(uxy, p[0] - p[1] - p[2] + p[3]) + rmul(uyz, p[0] - p[2] - p[4] + p[6])
         + rmul(uzx, p[0] - p[1] - p[4] + p[5])
         + rmul(uxyz, -p[0] + p[1] + p[2] - p[3] + p[4] - p[5] - p[6] + p[7]);
  endfunction

  function automatic noise_res_t noise_at(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    logic [31:0] raw[3];
    logic [7:0]  cell_idx[3];
    logic [7:0]  h;
    longint      f[3], u[3], du[3], t, q, ofs[3];
    longint      dotv[8], gq[3][8];
    longint      uxy, uyz, uzx, uxyz, kx, ky, kz, kxy, kyz, kzx, kall, sx, sy, sz;
    int          g[3];
    int          sel;
    noise_res_t  r;
    raw[0] = px; raw[1] = py; raw[2] = pz;
    for (int a = 0; a < 3; a++) begin
      cell_idx[a] = raw[a][FB +: 8];
      f[a] = longint'(raw[a] & 32'((ONE - 1)));
      t = rmul(f[a], 6 * f[a] - 15 * ONE) + 10 * ONE;
      u[a] = rmul(rmul(rmul(f[a], f[a]), f[a]), t);
      q = rmul(f[a], f[a] - ONE);
      du[a] = 30 * rmul(q, q);
    end
    for (int c = 0; c < 8; c++) begin
      h = gn3_pkg::PERM[8'(cell_idx[0] + c[0])];
      h = gn3_pkg::PERM[8'(h + cell_idx[1] + c[1])];
      h = gn3_pkg::PERM[8'(h + cell_idx[2] + c[2])];
      sel = h % 12;
      g[0] = gn3_pkg::GRAD_TAB[sel].gx;
      g[1] = gn3_pkg::GRAD_TAB[sel].gy;
      g[2] = gn3_pkg::GRAD_TAB[sel].gz;
      dotv[c] = 0;
      for (int a = 0; a < 3; a++) begin
        ofs[a] = f[a] - (c[a] ? ONE : 0);
        dotv[c] += g[a] * ofs[a];
        gq[a][c] = g[a] * ONE;
      end
    end
    uxy = rmul(u[0], u[1]); uyz = rmul(u[1], u[2]); uzx = rmul(u[2], u[0]);
    uxyz = rmul(uxy, u[2]);
    kx = dotv[1] - dotv[0]; ky = dotv[2] - dotv[0]; kz = dotv[4] - dotv[0];
    kxy = dotv[0] - dotv[1] - dotv[2] + dotv[3];
    kyz = dotv[0] - dotv[2] - dotv[4] + dotv[6];
    kzx = dotv[0] - dotv[1] - dotv[4] + dotv[5];
    kall = -dotv[0] + dotv[1] + dotv[2] - dotv[3] + dotv[4] - dotv[5] - dotv[6] + dotv[7];
    sx = kx + rmul(u[1], kxy) + rmul(u[2], kzx) + rmul(uyz, kall);
    sy = ky + rmul(u[2], kyz) + rmul(u[0], kxy) + rmul(uzx, kall);
    sz = kz + rmul(u[0], kzx) + rmul(u[1], kyz) + rmul(uxy, kall);
    r.noise_value = VW'(clamp(mix8(dotv, u[0], u[1], u[2], uxy, uyz, uzx, uxyz), VW));
    r.grad_x = GW'(clamp(mix8(gq[0], u[0], u[1], u[2], uxy, uyz, uzx, uxyz)
                         + rmul(du[0], sx), GW));
    r.grad_y = GW'(clamp(mix8(gq[1], u[0], u[1], u[2], uxy, uyz, uzx, uxyz)
                         + rmul(du[1], sy), GW));
    r.grad_z = GW'(clamp(mix8(gq[2], u[0], u[1], u[2], uxy, uyz, uzx, uxyz)
                         + rmul(du[2], sz), GW));
    return r;
  endfunction

  initial begin
    fail_count = 0;
    result_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    noise_res_t want;
    if (rst_n && in_mon.valid && in_mon.ready)
      expected_q.push_back(noise_at(in_mon.pos_x, in_mon.pos_y, in_mon.pos_z));
    if (rst_n && out_mon.valid && out_mon.ready) begin
      result_count <= result_count + 1;
      if (expected_q.size() == 0) begin
        $display("%0t: result item with nothing expected", $time);
        fail_count <= fail_count + 1;
      end else begin
        want = expected_q.pop_front();
        if (want.noise_value !== out_mon.noise_value || want.grad_x !== out_mon.grad_x ||
            want.grad_y !== out_mon.grad_y || want.grad_z !== out_mon.grad_z) begin
          $display("%0t: expected value %0d grad %0d %0d %0d, actual %0d grad %0d %0d %0d",
                   $time, want.noise_value, want.grad_x, want.grad_y, want.grad_z,
                   out_mon.noise_value, out_mon.grad_x, out_mon.grad_y, out_mon.grad_z);
          fail_count <= fail_count + 1;
        end
      end
    end
    pending_count = expected_q.size();
  end
endmodule

### tb/sv/gradient_noise_3d_with_derivative_core_tb.sv
// ----------------------------------------------------------------------------
// gradient_noise_3d_with_derivative_core_tb
// Drives points into the noise core with random idling on both sides; the
// checker beside the core predicts and compares every result item.
// ----------------------------------------------------------------------------
module gradient_noise_3d_with_derivative_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 600;
  localparam int QUIET_FROM = 500;   // no idling from this item onwards
  localparam int TIMEOUT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count, result_count;
  int   cycle_count = 0;
  int   sent_count = 0;

  gn3_in_if  in_chan ();
  gn3_out_if out_chan ();

  gradient_noise_3d_with_derivative_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  gradient_noise_3d_with_derivative_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The run is cut short if the core stops delivering results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver stalls in random bursts until the quiet part of the run.
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (sent_count < QUIET_FROM && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 12);
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Presents one point and holds it until it is taken. The valid stays high
  // when the next item follows straight on, so it is never lowered and raised
  // within the same step.
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int gap;
    in_chan.pos_x <= px;
    in_chan.pos_y <= py;
    in_chan.pos_z <= pz;
    in_chan.valid <= 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent_count++;
    if (sent_count < QUIET_FROM && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random coordinate: half the time near the origin with random fractions,
  // where cells and their neighbours vary, otherwise anywhere in the range.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return {{16{1'b0}}, 16'($urandom())} + ($urandom_range(0, 511) << 16)
                - (32'd256 << 16);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return {16'($urandom()), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals[10];
    in_chan.valid = 1'b0;
    in_chan.pos_x = '0;
    in_chan.pos_y = '0;
    in_chan.pos_z = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points: range extremes, exact lattice points, negative
    // coordinates, fractions just below one and cells where the index wraps.
    edge_vals = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h0001_0000, 32'h0000_FFFF, 32'h00FF_8000, 32'hFFFF_0000,
                  32'h0100_0001, 32'h0000_8000};
    for (int k = 0; k < 10; k++)
      send_point(edge_vals[k], edge_vals[(k + 3) % 10], edge_vals[(k + 7) % 10]);
    for (int k = 0; k < 10; k++)
      send_point(edge_vals[k], edge_vals[k], edge_vals[9 - k]);

    // Let the pipeline drain completely once before the random part.
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);

    for (int k = 0; k < N_RANDOM; k++)
      send_point(pick_coord(), pick_coord(), pick_coord());
    in_chan.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d points (directed extremes then random), checked %0d results.",
             sent_count, result_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### gradient_noise_3d_with_derivative_core.f
hdl/gn3_pkg.sv
hdl/gn3_if.sv
hdl/gn3_fade.sv
hdl/gn3_hash.sv
hdl/gn3_blend.sv
hdl/gradient_noise_3d_with_derivative_core.sv
tb/sv/gradient_noise_3d_with_derivative_checker.sv
tb/sv/gradient_noise_3d_with_derivative_core_tb.sv
